// ===== design/owm_pkg.sv =====
// Shared types, codes and constants of the one-wire bus master.
// No dependencies; every other file of the block but owm_fifo imports this package.
package owm_pkg;

  // Configuration registers
  localparam int unsigned RegCount = 8;
  localparam int unsigned RegW     = 10;
  localparam int unsigned RegIdxW  = 3;

  // Default timer width and queue depth
  localparam int unsigned TimerBitsDef = 10;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SLOT_LOW      = 3'd3,
    REG_READ_SAMPLE   = 3'd4,
    REG_READ_TAIL     = 3'd5,
    REG_WRITE_HOLD    = 3'd6,
    REG_RECOVERY      = 3'd7
  } reg_idx_e;

  localparam logic [RegW-1:0] RegDefaults [RegCount] = '{
    10'd480, 10'd100, 10'd380, 10'd2, 10'd10, 10'd49, 10'd58, 10'd10
  };

  typedef enum logic [2:0] {
    OP_RESET      = 3'd0,
    OP_WRITE_BIT  = 3'd1,
    OP_READ_BIT   = 3'd2,
    OP_WRITE_BYTE = 3'd3,
    OP_READ_BYTE  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_WAIT   = 4'd2,
    PH_RST_TAIL   = 4'd3,
    PH_SLOT_LOW   = 4'd4,
    PH_READ_WAIT  = 4'd5,
    PH_READ_TAIL  = 4'd6,
    PH_WRITE_HOLD = 4'd7,
    PH_RECOVERY   = 4'd8
  } phase_e;

  // One bus tick as it arrives
  typedef struct packed {
    logic       start_req;
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  // One tick after classification: start only if the opcode is legal
  typedef struct packed {
    logic       start;
    op_e        op;
    logic [7:0] data_byte;
    logic       line_level;
  } cmd_t;

  // Bus state reported after each tick
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } out_item_t;

endpackage

// ===== design/one_wire_bus_master.sv =====
// One-wire bus master. Each pushed item is one bus tick (one microsecond) carrying an
// optional command and the sampled line level; each tick yields exactly one result
// with the open-drain drive, busy, done, presence and last read data, in push order.
// One item per cycle is sustained while the result queue has room; a pushed item is
// registered in the input queue, then the sequencer works on the queue head in the
// cycle that writes the result queue. Slot timings come from eight 10-bit tick-count
// registers, which the user writes at idle; the block itself does not enforce this.
// Depends on owm_pkg, owm_fifo, owm_front and owm_seq.
module one_wire_bus_master #(
  parameter int unsigned TimerBits  = owm_pkg::TimerBitsDef,
  parameter int unsigned QueueDepth = owm_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  owm_pkg::in_item_t           in_item_i,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output owm_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [owm_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [owm_pkg::RegW-1:0]    cfg_wdata_i
);
  import owm_pkg::*;

  cmd_t      cmd;
  logic      cmd_empty, cmd_take, res_full, res_push;
  out_item_t res;

  owm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_take),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  owm_seq #(
    .TimerBits (TimerBits)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tick_valid_i (!cmd_empty),
    .cmd_i        (cmd),
    .tick_take_o  (cmd_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // Queue results toward the consumer
  owm_fifo #(
    .ItemT (out_item_t),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

// ===== design/owm_fifo.sv =====
// Small synchronous queue carrying one packed item type.
// Depends on nothing; used between the front, the sequencer and the result side.
module owm_fifo #(
  parameter type         ItemT = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ItemT wdata_i,
  output logic full_o,
  input  logic pop_i,
  output ItemT rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ItemT            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/owm_front.sv =====
// Front end: classifies incoming ticks and queues them for the sequencer.
// Depends on owm_pkg and owm_fifo.
module owm_front #(
  parameter int unsigned Depth = owm_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  owm_pkg::in_item_t in_item_i,
  output logic              full_o,
  input  logic              cmd_pop_i,
  output owm_pkg::cmd_t     cmd_o,
  output logic              cmd_empty_o
);
  import owm_pkg::*;

  cmd_t cmd_in;

  // Drop start requests with an illegal opcode
  always_comb begin
    cmd_in.line_level = in_item_i.line_level;
    cmd_in.data_byte  = in_item_i.data_byte;
    if (in_item_i.op <= OP_READ_BYTE) begin
      cmd_in.start = in_item_i.start_req;
      cmd_in.op    = op_e'(in_item_i.op);
    end else begin
      cmd_in.start = 1'b0;
      cmd_in.op    = OP_RESET;
    end
  end

  owm_fifo #(
    .ItemT (cmd_t),
    .Depth (Depth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== design/owm_seq.sv =====
// Back end: bus slot sequencer with timing registers.
// One tick per cycle while the result queue has room; depends on owm_pkg.
module owm_seq #(
  parameter int unsigned TimerBits = owm_pkg::TimerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owm_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [owm_pkg::RegW-1:0]      cfg_wdata_i,
  input  logic                          tick_valid_i,
  input  owm_pkg::cmd_t                 cmd_i,
  output logic                          tick_take_o,
  input  logic                          res_full_i,
  output logic                          res_push_o,
  output owm_pkg::out_item_t            res_o
);
  import owm_pkg::*;

  localparam int unsigned CmpW = (TimerBits > RegW) ? TimerBits : RegW;
  localparam logic [CmpW-1:0] TimerMax = CmpW'((64'd1 << TimerBits) - 64'd1);

  logic [RegW-1:0]      regs_q [RegCount];
  phase_e               phase_q, phase_d, phase_e0;
  logic [TimerBits-1:0] timer_q, timer_d, timer_e0, timer_inc;
  logic [2:0]           bit_idx_q, bit_idx_d, bit_idx_e0;
  logic [7:0]           shreg_q, shreg_d, shreg_e0;
  op_e                  op_q, op_d, op_e0;
  logic                 pres_q, pres_d;
  logic [7:0]           rhold_q, rhold_d;
  logic                 start_ok, drive, busy, done;
  reg_idx_e             dur_sel;
  logic [CmpW-1:0]      dur_raw, dur;

  assign tick_take_o = tick_valid_i && !res_full_i;
  assign res_push_o  = tick_take_o;

  // Launch a command on an idle tick
  always_comb begin
    start_ok   = cmd_i.start && (phase_q == PH_IDLE);
    phase_e0   = phase_q;
    op_e0      = op_q;
    shreg_e0   = shreg_q;
    bit_idx_e0 = bit_idx_q;
    timer_e0   = timer_q;
    if (start_ok) begin
      phase_e0   = (cmd_i.op == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
      op_e0      = cmd_i.op;
      shreg_e0   = cmd_i.data_byte;
      bit_idx_e0 = '0;
      timer_e0   = '0;
    end
  end

  // Pick the phase length; zero acts as one, clamp to the timer range
  always_comb begin
    unique case (phase_e0)
      PH_RST_LOW:    dur_sel = REG_RESET_LOW;
      PH_RST_WAIT:   dur_sel = REG_PRESENCE_WAIT;
      PH_RST_TAIL:   dur_sel = REG_RESET_TAIL;
      PH_SLOT_LOW:   dur_sel = REG_SLOT_LOW;
      PH_READ_WAIT:  dur_sel = REG_READ_SAMPLE;
      PH_READ_TAIL:  dur_sel = REG_READ_TAIL;
      PH_WRITE_HOLD: dur_sel = REG_WRITE_HOLD;
      default:       dur_sel = REG_RECOVERY;
    endcase
    dur_raw = CmpW'(regs_q[dur_sel]);
    if (dur_raw == '0) begin
      dur = CmpW'(1);
    end else if (dur_raw > TimerMax) begin
      dur = TimerMax;
    end else begin
      dur = dur_raw;
    end
  end

  // Bus drive and busy for this tick
  always_comb begin
    busy = (phase_e0 != PH_IDLE);
    unique case (phase_e0)
      PH_RST_LOW, PH_SLOT_LOW: drive = 1'b1;
      PH_WRITE_HOLD:           drive = ~shreg_e0[0];
      default:                 drive = 1'b0;
    endcase
  end

  // Next state: count the phase, then move on at its end
  always_comb begin
    phase_d   = phase_e0;
    op_d      = op_e0;
    shreg_d   = shreg_e0;
    bit_idx_d = bit_idx_e0;
    timer_d   = timer_e0;
    pres_d    = pres_q;
    rhold_d   = rhold_q;
    done      = 1'b0;
    timer_inc = timer_e0 + 1'b1;
    if (busy) begin
      if (CmpW'(timer_inc) >= dur) begin
        timer_d = '0;
        unique case (phase_e0)
          PH_RST_LOW: phase_d = PH_RST_WAIT;
          PH_RST_WAIT: begin
            pres_d  = ~cmd_i.line_level;
            phase_d = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          PH_SLOT_LOW: begin
            phase_d = (op_e0 == OP_READ_BIT || op_e0 == OP_READ_BYTE) ?
                      PH_READ_WAIT : PH_WRITE_HOLD;
          end
          PH_READ_WAIT: begin
            shreg_d = {cmd_i.line_level, shreg_e0[7:1]};
            phase_d = PH_READ_TAIL;
          end
          PH_WRITE_HOLD: phase_d = PH_RECOVERY;
          PH_READ_TAIL, PH_RECOVERY: begin
            if (phase_e0 == PH_RECOVERY) begin
              shreg_d = {1'b0, shreg_e0[7:1]};
            end
            if ((op_e0 == OP_WRITE_BYTE || op_e0 == OP_READ_BYTE) &&
                (bit_idx_e0 != 3'd7)) begin
              bit_idx_d = bit_idx_e0 + 1'b1;
              phase_d   = PH_SLOT_LOW;
            end else begin
              if (op_e0 == OP_READ_BIT) begin
                rhold_d = {7'd0, shreg_d[7]};
              end else if (op_e0 == OP_READ_BYTE) begin
                rhold_d = shreg_d;
              end
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end else begin
        timer_d = timer_inc;
      end
    end
  end

  // Report the tick result
  always_comb begin
    res_o.drive_low = drive;
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.presence  = pres_d;
    res_o.read_data = rhold_d;
  end

  // Hold timing registers; writes take effect at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= RegDefaults[i];
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Advance the sequencer on each taken tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      bit_idx_q <= '0;
      shreg_q   <= '0;
      op_q      <= OP_RESET;
      pres_q    <= 1'b0;
      rhold_q   <= '0;
    end else if (tick_take_o) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_idx_q <= bit_idx_d;
      shreg_q   <= shreg_d;
      op_q      <= op_d;
      pres_q    <= pres_d;
      rhold_q   <= rhold_d;
    end
  end

endmodule
